// ===== rtl/sbe_pkg.sv =====
// Shared types, codes and constants of the stack bytecode executor.
package sbe_pkg;

  localparam int DATA_W            = 32;
  localparam int OUT_PC_W          = 24;
  localparam int DEF_STACK_DEPTH   = 256;
  localparam int DEF_GLOBAL_COUNT  = 256;
  localparam int DEF_CALL_DEPTH    = 64;
  localparam int DEF_PC_BITS       = 24;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_BOOL = 2'd1;
  localparam logic [1:0] KIND_FUNC = 2'd2;

  typedef enum logic [4:0] {
    OP_PUSHC   = 5'd0,
    OP_POP     = 5'd1,
    OP_GSTORE  = 5'd2,
    OP_STLOC   = 5'd3,
    OP_LOAD    = 5'd4,
    OP_LDLOC   = 5'd5,
    OP_ADD     = 5'd6,
    OP_SUB     = 5'd7,
    OP_MUL     = 5'd8,
    OP_DIV     = 5'd9,
    OP_LT      = 5'd10,
    OP_GT      = 5'd11,
    OP_LE      = 5'd12,
    OP_GE      = 5'd13,
    OP_EQ      = 5'd14,
    OP_NE      = 5'd15,
    OP_JUMP    = 5'd16,
    OP_JFALSE  = 5'd17,
    OP_CALL    = 5'd18,
    OP_RET     = 5'd19,
    OP_EMIT    = 5'd20,
    OP_HALT    = 5'd21
  } op_t;

  typedef enum logic [3:0] {
    SB_RUN     = 4'd0,
    SB_FINISH  = 4'd1,
    SB_TYPE    = 4'd2,
    SB_DIVZ    = 4'd3,
    SB_UNDER   = 4'd4,
    SB_RANGE   = 4'd5,
    SB_DEPTH   = 4'd6,
    SB_NOTCALL = 4'd7,
    SB_ARGS    = 4'd8,
    SB_BADOP   = 4'd9,
    SB_STOPPED = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] bits;
  } cell_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic div_start;
    logic commit;
  } sbe_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_done;
    logic out_free;
  } sbe_sts_t;

endpackage

// ===== rtl/sbe_in_if.sv =====
// Instruction channel of the stack bytecode executor.
interface sbe_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         operation;
  logic signed [15:0] operand;
  logic [1:0]         const_kind;
  logic signed [31:0] const_value;

  modport source(output valid, operation, operand, const_kind, const_value, input ready);
  modport sink(input valid, operation, operand, const_kind, const_value, output ready);
endinterface

// ===== rtl/sbe_out_if.sv =====
// Result channel of the stack bytecode executor.
interface sbe_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        next_pc;
  logic [3:0]         status;
  logic               print_valid;
  logic [1:0]         print_kind;
  logic signed [31:0] print_value;

  modport source(output valid, next_pc, status, print_valid, print_kind, print_value,
                 input ready);
  modport sink(input valid, next_pc, status, print_valid, print_kind, print_value,
               output ready);
endinterface

// ===== rtl/sbe_cfg_if.sv =====
// Configuration write channel of the stack bytecode executor.
interface sbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] main_entry_address;

  modport source(output valid, main_entry_address, input ready);
  modport sink(input valid, main_entry_address, output ready);
endinterface

// ===== rtl/sbe_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module sbe_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sbe_pkg::DATA_W-1:0] dividend,
  input  logic [sbe_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [sbe_pkg::DATA_W-1:0] quotient
);
  import sbe_pkg::*;

  localparam int CW = $clog2(DATA_W + 1);

  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [DATA_W+1:0] diff;

  assign diff = {1'b0, rem_r, quo_r[DATA_W-1]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(DATA_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      quo_r <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      dvs_r <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[DATA_W+1]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + DATA_W'(1)) : quo_r;
endmodule

// ===== rtl/sbe_ctrl.sv =====
// Sequencer of the stack bytecode executor: clear pass, fetch, execute, divide.
module sbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbe_pkg::sbe_sts_t sts,
  output sbe_pkg::sbe_cmd_t cmd
);
  import sbe_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done && sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end
endmodule

// ===== rtl/sbe_dp.sv =====
// Datapath: value stack, globals, call frames, ALU, machine registers and result register.
module sbe_dp #(
  parameter int STACK_DEPTH  = sbe_pkg::DEF_STACK_DEPTH,
  parameter int GLOBAL_COUNT = sbe_pkg::DEF_GLOBAL_COUNT,
  parameter int CALL_DEPTH   = sbe_pkg::DEF_CALL_DEPTH,
  parameter int PC_BITS      = sbe_pkg::DEF_PC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbe_pkg::sbe_cmd_t   cmd,
  output sbe_pkg::sbe_sts_t   sts,
  input  logic [4:0]          in_operation,
  input  logic signed [15:0]  in_operand,
  input  logic [1:0]          in_const_kind,
  input  logic signed [31:0]  in_const_value,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [23:0]         out_next_pc,
  output logic [3:0]          out_status,
  output logic                out_print_valid,
  output logic [1:0]          out_print_kind,
  output logic signed [31:0]  out_print_value
);
  import sbe_pkg::*;

  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int TW   = $clog2(STACK_DEPTH + 1);
  localparam int GA_W = $clog2(GLOBAL_COUNT);
  localparam int FI_W = $clog2(CALL_DEPTH);
  localparam int FW   = $clog2(CALL_DEPTH + 1);
  localparam int FDW  = PC_BITS + SA_W;
  localparam int IW   = 18;

  // Storage.
  cell_t            stack_mem [STACK_DEPTH];
  cell_t            glob_mem  [GLOBAL_COUNT];
  logic [FDW-1:0]   frame_mem [CALL_DEPTH];

  // Machine registers.
  logic [TW-1:0]      top_r;
  logic [SA_W-1:0]    base_r;
  logic [FW-1:0]      depth_r;
  logic [PC_BITS-1:0] pc_r;
  logic               stopped_r;
  logic               executed_r;
  logic [GA_W-1:0]    clr_cnt_r;

  // Latched instruction and read data.
  logic [4:0]         op_r;
  logic signed [15:0] opd_r;
  logic [1:0]         ck_r;
  logic [31:0]        cv_r;
  cell_t              rda_r;
  cell_t              rdb_r;
  cell_t              rdg_r;
  logic [FDW-1:0]     rdf_r;

  // Result register.
  logic               out_valid_r;
  logic [23:0]        out_pc_r;
  logic [3:0]         out_st_r;
  logic               out_pv_r;
  logic [1:0]         out_pk_r;
  logic [31:0]        out_pval_r;

  // Read addresses at accept.
  logic [SA_W-1:0]    ra_addr;
  logic [SA_W-1:0]    rb_addr;
  logic signed [IW-1:0] lidx_in;
  logic [16:0]        slot_in;

  // Execute results.
  status_t            e_st;
  logic [PC_BITS-1:0] e_npc;
  logic [PC_BITS-1:0] jmp_pc;
  logic               e_pv;
  logic [1:0]         e_pk;
  logic [31:0]        e_pval;
  logic               s_we;
  logic [SA_W-1:0]    s_wa;
  cell_t              s_wd;
  logic               g_we;
  logic               f_we;
  logic [TW-1:0]      top_nxt;
  logic [SA_W-1:0]    base_nxt;
  logic [FW-1:0]      depth_nxt;
  logic signed [IW-1:0] lidx;
  logic               l_ok;
  logic               g_ok;
  logic               full;
  logic               empty;
  logic [16:0]        slot_ex;
  cell_t              alu_c;
  logic               ok;
  logic [31:0]        div_q;
  logic               div_done;
  logic [GA_W-1:0]    g_wa;
  cell_t              g_wd;

  function automatic logic signed [IW-1:0] loc_idx(input logic [SA_W-1:0] b,
                                                    input logic signed [15:0] o);
    return $signed({{(IW - SA_W){1'b0}}, b}) + IW'(o);
  endfunction

  sbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rdb_r.bits),
    .divisor  (rda_r.bits),
    .done     (div_done),
    .quotient (div_q)
  );

  // Accept-time addresses: A is the top entry, B the second, a local slot or the callee.
  always_comb begin
    lidx_in = loc_idx(base_r, in_operand);
    slot_in = 17'(top_r) - 17'($unsigned(in_operand)) - 17'd1;
    ra_addr = SA_W'(top_r - TW'(1));
    case (in_operation) inside
      OP_LDLOC: rb_addr = lidx_in[SA_W-1:0];
      OP_CALL:  rb_addr = slot_in[SA_W-1:0];
      default:  rb_addr = SA_W'(top_r - TW'(2));
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      opd_r <= in_operand;
      ck_r  <= in_const_kind;
      cv_r  <= in_const_value;
      rda_r <= stack_mem[ra_addr];
      rdb_r <= stack_mem[rb_addr];
      rdg_r <= glob_mem[in_operand[GA_W-1:0]];
      rdf_r <= frame_mem[FI_W'(depth_r - FW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && ok && s_we) begin
      stack_mem[s_wa] <= s_wd;
    end
  end

  assign g_wa = cmd.clr_wr ? clr_cnt_r : opd_r[GA_W-1:0];
  assign g_wd = cmd.clr_wr ? cell_t'('0) : rda_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || (cmd.commit && ok && g_we)) begin
      glob_mem[g_wa] <= g_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && ok && f_we) begin
      frame_mem[FI_W'(depth_r - FW'(1))] <= {PC_BITS'(pc_r + PC_BITS'(1)), base_r};
    end
  end

  // Two-operand ALU on the second (b) and top (a) entries.
  always_comb begin
    alu_c.kind = KIND_INT;
    alu_c.bits = '0;
    case (op_r)
      OP_ADD: alu_c.bits = rdb_r.bits + rda_r.bits;
      OP_SUB: alu_c.bits = rdb_r.bits - rda_r.bits;
      OP_MUL: alu_c.bits = 32'(rdb_r.bits * rda_r.bits);
      OP_DIV: alu_c.bits = div_q;
      OP_LT: begin
        alu_c.kind = KIND_BOOL;
        alu_c.bits = {31'b0, $signed(rdb_r.bits) < $signed(rda_r.bits)};
      end
      OP_GT: begin
        alu_c.kind = KIND_BOOL;
        alu_c.bits = {31'b0, $signed(rdb_r.bits) > $signed(rda_r.bits)};
      end
      OP_LE: begin
        alu_c.kind = KIND_BOOL;
        alu_c.bits = {31'b0, $signed(rdb_r.bits) <= $signed(rda_r.bits)};
      end
      OP_GE: begin
        alu_c.kind = KIND_BOOL;
        alu_c.bits = {31'b0, $signed(rdb_r.bits) >= $signed(rda_r.bits)};
      end
      OP_EQ: begin
        alu_c.kind = KIND_BOOL;
        alu_c.bits = {31'b0, rdb_r.bits == rda_r.bits};
      end
      OP_NE: begin
        alu_c.kind = KIND_BOOL;
        alu_c.bits = {31'b0, rdb_r.bits != rda_r.bits};
      end
      default: alu_c.bits = '0;
    endcase
  end

  always_comb begin
    lidx      = loc_idx(base_r, opd_r);
    l_ok      = (lidx >= 0) && (lidx < IW'(STACK_DEPTH));
    g_ok      = !opd_r[15] && ({1'b0, opd_r} < 17'(GLOBAL_COUNT));
    full      = (top_r == TW'(STACK_DEPTH));
    empty     = (top_r == '0);
    slot_ex   = 17'(top_r) - 17'($unsigned(opd_r)) - 17'd1;
    jmp_pc    = pc_r + PC_BITS'(1) + PC_BITS'(opd_r);
    e_st      = SB_RUN;
    e_npc     = pc_r + PC_BITS'(1);
    e_pv      = 1'b0;
    e_pk      = KIND_INT;
    e_pval    = '0;
    s_we      = 1'b0;
    s_wa      = SA_W'(top_r);
    s_wd      = rda_r;
    g_we      = 1'b0;
    f_we      = 1'b0;
    top_nxt   = top_r;
    base_nxt  = base_r;
    depth_nxt = depth_r;
    case (op_r)
      OP_PUSHC: begin
        if (ck_r > KIND_FUNC) begin
          e_st = SB_TYPE;
        end else if (full) begin
          e_st = SB_RANGE;
        end else begin
          s_we      = 1'b1;
          s_wd.kind = ck_r;
          s_wd.bits = (ck_r == KIND_BOOL) ? {31'b0, |cv_r} : cv_r;
          top_nxt   = top_r + TW'(1);
        end
      end
      OP_POP: begin
        if (empty) e_st = SB_UNDER;
        else top_nxt = top_r - TW'(1);
      end
      OP_GSTORE: begin
        if (empty) begin
          e_st = SB_UNDER;
        end else if (!g_ok) begin
          e_st = SB_RANGE;
        end else begin
          g_we    = 1'b1;
          top_nxt = top_r - TW'(1);
        end
      end
      OP_STLOC: begin
        if (empty) begin
          e_st = SB_UNDER;
        end else if (!l_ok) begin
          e_st = SB_RANGE;
        end else begin
          s_we    = 1'b1;
          s_wa    = lidx[SA_W-1:0];
          top_nxt = top_r - TW'(1);
        end
      end
      OP_LOAD, OP_LDLOC: begin
        if ((op_r == OP_LOAD) ? !g_ok : !l_ok) begin
          e_st = SB_RANGE;
        end else if (full) begin
          e_st = SB_RANGE;
        end else begin
          s_we    = 1'b1;
          s_wd    = (op_r == OP_LOAD) ? rdg_r : rdb_r;
          top_nxt = top_r + TW'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
        if (top_r < TW'(2)) begin
          e_st = SB_UNDER;
        end else if ((op_r == OP_EQ) || (op_r == OP_NE)) begin
          if ((rdb_r.kind != rda_r.kind) || (rdb_r.kind == KIND_FUNC)) e_st = SB_TYPE;
        end else if ((rdb_r.kind != KIND_INT) || (rda_r.kind != KIND_INT)) begin
          e_st = SB_TYPE;
        end else if ((op_r == OP_DIV) && (rda_r.bits == '0)) begin
          e_st = SB_DIVZ;
        end
        s_we    = 1'b1;
        s_wa    = SA_W'(top_r - TW'(2));
        s_wd    = alu_c;
        top_nxt = top_r - TW'(1);
      end
      OP_JUMP: e_npc = jmp_pc;
      OP_JFALSE: begin
        if (empty) begin
          e_st = SB_UNDER;
        end else begin
          top_nxt = top_r - TW'(1);
          // A function value counts as false.
          if (!((rda_r.kind != KIND_FUNC) && (rda_r.bits != '0))) e_npc = jmp_pc;
        end
      end
      OP_CALL: begin
        if (opd_r[15] || (({1'b0, opd_r} + 17'd1) > 17'(top_r))) begin
          e_st = SB_UNDER;
        end else if (rdb_r.kind != KIND_FUNC) begin
          e_st = SB_NOTCALL;
        end else if ({8'b0, rdb_r.bits[31:24]} != opd_r) begin
          e_st = SB_ARGS;
        end else if ((depth_r == '0) || (depth_r >= FW'(CALL_DEPTH))) begin
          e_st = SB_DEPTH;
        end else begin
          f_we      = 1'b1;
          depth_nxt = depth_r + FW'(1);
          base_nxt  = slot_ex[SA_W-1:0];
          e_npc     = rdb_r.bits[PC_BITS-1:0];
        end
      end
      OP_RET: begin
        if (empty) begin
          e_st = SB_UNDER;
        end else if (depth_r <= FW'(1)) begin
          // Returning from the main frame ends the program.
          e_st = SB_FINISH;
        end else begin
          depth_nxt = depth_r - FW'(1);
          s_we      = 1'b1;
          s_wa      = base_r;
          top_nxt   = TW'(base_r) + TW'(1);
          base_nxt  = rdf_r[SA_W-1:0];
          e_npc     = rdf_r[FDW-1:SA_W];
        end
      end
      OP_EMIT: begin
        if (empty) begin
          e_st = SB_UNDER;
        end else begin
          top_nxt = top_r - TW'(1);
          if (rda_r.kind != KIND_FUNC) begin
            e_pv   = 1'b1;
            e_pk   = rda_r.kind;
            e_pval = rda_r.bits;
          end
        end
      end
      OP_HALT: e_st = SB_FINISH;
      default: e_st = SB_BADOP;
    endcase
    if (stopped_r) e_st = SB_STOPPED;
  end

  assign ok = (e_st == SB_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= '0;
      base_r     <= '0;
      depth_r    <= FW'(1);
      pc_r       <= '0;
      stopped_r  <= 1'b0;
      executed_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + GA_W'(1);
      end
      if (cmd.commit) begin
        executed_r <= 1'b1;
        if (ok) begin
          pc_r       <= e_npc;
          top_r      <= top_nxt;
          base_r     <= base_nxt;
          depth_r    <= depth_nxt;
        end else begin
          stopped_r <= 1'b1;
        end
      end else if (cfg_we && !executed_r) begin
        pc_r <= PC_BITS'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pc_r   <= 24'(ok ? e_npc : pc_r);
      out_st_r   <= e_st;
      out_pv_r   <= ok & e_pv;
      out_pk_r   <= ok ? e_pk : KIND_INT;
      out_pval_r <= ok ? e_pval : '0;
    end
  end

  assign sts.clr_last = (clr_cnt_r == GA_W'(GLOBAL_COUNT - 1));
  assign sts.need_div = (op_r == OP_DIV) && ok;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_status      = out_st_r;
  assign out_print_valid = out_pv_r;
  assign out_print_kind  = out_pk_r;
  assign out_print_value = out_pval_r;
endmodule

// ===== rtl/stack_bytecode_executor.sv =====
// Top level of the stack bytecode executor: sequencer plus datapath.
//
// Usage: each transaction on in_ch carries one fetched instruction (operation,
// operand and, for const, the constant kind and value). Each instruction gives
// exactly one transaction on out_ch with the next fetch address, a status and
// any printed value. cfg_ch writes the main entry address; it is always ready
// and loads the program counter as long as no instruction has run since reset.
// Timing: an instruction is accepted with stack, global and frame reads, then
// executed and written back. Division runs a serial divider at one quotient
// bit per cycle. One instruction is in work at a time; the result register lets
// the next instruction be accepted while the previous result waits on out_ch.
// Reset: rst_n is synchronous. After reset a clearing pass writes integer zero
// into every global, during which in_ch is not ready.
// Stall: while a result waits on out_ch, a finished instruction holds in the
// execute or divide step until the register frees; nothing more is accepted.
// After an error or a halt every instruction answers with status stopped.
module stack_bytecode_executor #(
  parameter int STACK_DEPTH  = sbe_pkg::DEF_STACK_DEPTH,
  parameter int GLOBAL_COUNT = sbe_pkg::DEF_GLOBAL_COUNT,
  parameter int CALL_DEPTH   = sbe_pkg::DEF_CALL_DEPTH,
  parameter int PC_BITS      = sbe_pkg::DEF_PC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  sbe_in_if.sink     in_ch,
  sbe_out_if.source  out_ch,
  sbe_cfg_if.sink    cfg_ch
);
  import sbe_pkg::*;

  sbe_cmd_t cmd;
  sbe_sts_t sts;
  logic     in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbe_dp #(
    .STACK_DEPTH  (STACK_DEPTH),
    .GLOBAL_COUNT (GLOBAL_COUNT),
    .CALL_DEPTH   (CALL_DEPTH),
    .PC_BITS      (PC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_operand      (in_ch.operand),
    .in_const_kind   (in_ch.const_kind),
    .in_const_value  (in_ch.const_value),
    .cfg_we          (cfg_ch.valid),
    .cfg_data        (cfg_ch.main_entry_address),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_next_pc     (out_ch.next_pc),
    .out_status      (out_ch.status),
    .out_print_valid (out_ch.print_valid),
    .out_print_kind  (out_ch.print_kind),
    .out_print_value (out_ch.print_value)
  );
endmodule
